// File: src/olid_pkg.sv
// Shared types and codes for the ordered list insert/delete unit.
package olid_pkg;

   localparam int DATA_W  = 32;
   localparam int POS_W   = 8;
   localparam int KIND_W  = 2;
   localparam int STAT_W  = 3;
   localparam int LEN_W   = 5;

   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DUMP   = 2'd2;

   localparam logic [STAT_W-1:0] STAT_DONE       = 3'd0;
   localparam logic [STAT_W-1:0] STAT_FULL       = 3'd1;
   localparam logic [STAT_W-1:0] STAT_EMPTY      = 3'd2;
   localparam logic [STAT_W-1:0] STAT_ENTRY      = 3'd3;
   localparam logic [STAT_W-1:0] STAT_EMPTY_DUMP = 3'd4;

   localparam logic [1:0] CELL_HOLD   = 2'd0;
   localparam logic [1:0] CELL_INSERT = 2'd1;
   localparam logic [1:0] CELL_DELETE = 2'd2;
   localparam logic [1:0] CELL_ROTATE = 2'd3;

   typedef struct packed {
      logic [1:0]               op;
      logic signed [DATA_W-1:0] value;
   } cell_cmd_type;

endpackage

// File: src/olid_cell.sv
// One storage cell of the list chain; shifts with its neighbors on command.
module olid_cell import olid_pkg::*; #(
   parameter int IDX = 0,
   parameter int CW  = 5
) (
   input  logic                     clock,
   input  cell_cmd_type             cmd,
   input  logic [CW-1:0]            pos,
   input  logic [CW-1:0]            count,
   input  logic signed [DATA_W-1:0] prev_value,
   input  logic signed [DATA_W-1:0] next_value,
   input  logic signed [DATA_W-1:0] head_value,
   output logic signed [DATA_W-1:0] value
);

   localparam logic [CW-1:0] MY  = CW'(IDX);
   localparam logic [CW-1:0] MY1 = CW'(IDX + 1);

   logic signed [DATA_W-1:0] value_ff;
   logic signed [DATA_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      unique case (cmd.op)
         CELL_INSERT: begin
            if (MY == pos) begin
               value_in = cmd.value;
            end else if (MY > pos && MY <= count) begin
               value_in = prev_value;
            end
         end
         CELL_DELETE: begin
            if (MY >= pos && MY1 < count) begin
               value_in = next_value;
            end
         end
         CELL_ROTATE: begin
            if (MY1 < count) begin
               value_in = next_value;
            end else if (MY1 == count) begin
               value_in = head_value;
            end
         end
         default: value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

// File: src/ordered_list_insert_delete_unit.sv
// Ordered list unit: insert, delete and in-order dump over a chain of shift cells.
// Holds up to CAPACITY signed 32-bit values in a row of cells. On an insert or a
// delete, every cell at or past the target shifts by one toward its neighbor in
// the same cycle, and the single result word is registered.
// A dump first enters the dump state and then streams one entry per cycle from
// the head cell while the chain rotates and the output is not stalled; no new
// request is taken until its last word has been loaded into the output register.
// While idle, a new request is taken whenever the output register is empty or
// being drained in the same cycle. Length wraps modulo 32.
module ordered_list_insert_delete_unit import olid_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [KIND_W-1:0]        req_kind,
   input  logic signed [POS_W-1:0]  req_position,
   input  logic signed [DATA_W-1:0] req_value_in,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [STAT_W-1:0]        rsp_status,
   output logic signed [DATA_W-1:0] rsp_value_out,
   output logic [LEN_W-1:0]         rsp_length,
   output logic                     rsp_last
);

   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;

   localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_DUMP = 1'b1;

   logic                     state_ff, state_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [CW-1:0]            idx_ff, idx_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]        rsp_status_ff, rsp_status_in;
   logic signed [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic [CW-1:0]            rsp_count_ff, rsp_count_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic signed [DATA_W-1:0] cell_val [CAPACITY];
   cell_cmd_type             cmd;
   logic [CW-1:0]            cmd_pos;

   logic                     out_free;
   logic                     accept;
   logic [CW-1:0]            count_m1;
   logic [CMPW-1:0]          pos_ext;
   logic [CW-1:0]            ins_pos;
   logic [CW-1:0]            del_pos;
   logic [CW-1:0]            idx_next;
   logic [CW+LEN_W-1:0]      count_wide;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff == ST_DUMP) || !out_free;
   assign accept    = req_valid && !req_stall;

   assign count_m1 = count_ff - CW'(1);
   assign pos_ext  = CMPW'(req_position[POS_W-2:0]);
   assign idx_next = idx_ff + CW'(1);

   always_comb begin
      if (req_position[POS_W-1] || pos_ext >= CMPW'(count_ff)) begin
         ins_pos = count_ff;
      end else begin
         ins_pos = pos_ext[CW-1:0];
      end
      if (req_position[POS_W-1] || pos_ext >= CMPW'(count_m1)) begin
         del_pos = count_m1;
      end else begin
         del_pos = pos_ext[CW-1:0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      cmd.op        = CELL_HOLD;
      cmd.value     = req_value_in;
      cmd_pos       = ins_pos;

      if (out_free) begin
         rsp_valid_in = 1'b0;
      end

      if (state_ff == ST_DUMP) begin
         if (out_free) begin
            cmd.op        = CELL_ROTATE;
            rsp_valid_in  = 1'b1;
            rsp_status_in = STAT_ENTRY;
            rsp_value_in  = cell_val[0];
            rsp_count_in  = count_ff;
            rsp_last_in   = (idx_next == count_ff);
            idx_in        = idx_next;
            if (idx_next == count_ff) begin
               state_in = ST_IDLE;
            end
         end
      end else if (accept) begin
         rsp_value_in = '0;
         rsp_last_in  = 1'b1;
         rsp_status_in = STAT_DONE;
         rsp_count_in = count_ff;
         rsp_valid_in = 1'b1;
         unique case (req_kind)
            KIND_INSERT: begin
               if (count_ff == FULL_COUNT) begin
                  rsp_status_in = STAT_FULL;
               end else begin
                  cmd.op       = CELL_INSERT;
                  count_in     = count_ff + CW'(1);
                  rsp_count_in = count_ff + CW'(1);
               end
            end
            KIND_DELETE: begin
               if (count_ff == '0) begin
                  rsp_status_in = STAT_EMPTY;
               end else begin
                  cmd.op       = CELL_DELETE;
                  cmd_pos      = del_pos;
                  rsp_value_in = cell_val[del_pos[IW-1:0]];
                  count_in     = count_m1;
                  rsp_count_in = count_m1;
               end
            end
            KIND_DUMP: begin
               if (count_ff == '0) begin
                  rsp_status_in = STAT_EMPTY_DUMP;
               end else begin
                  rsp_valid_in = 1'b0;
                  state_in     = ST_DUMP;
                  idx_in       = '0;
               end
            end
            default: rsp_status_in = STAT_DONE;
         endcase
      end
   end

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         logic signed [DATA_W-1:0] prev_v;
         logic signed [DATA_W-1:0] next_v;
         if (g == 0) begin : g_first
            assign prev_v = '0;
         end else begin : g_mid_prev
            assign prev_v = cell_val[g-1];
         end
         if (g == CAPACITY - 1) begin : g_last
            assign next_v = '0;
         end else begin : g_mid_next
            assign next_v = cell_val[g+1];
         end
         olid_cell #(
            .IDX (g),
            .CW  (CW)
         ) u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .pos        (cmd_pos),
            .count      (count_ff),
            .prev_value (prev_v),
            .next_value (next_v),
            .head_value (cell_val[0]),
            .value      (cell_val[g])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign count_wide    = {{LEN_W{1'b0}}, rsp_count_ff};
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_length    = count_wide[LEN_W-1:0];
   assign rsp_last      = rsp_last_ff;

endmodule
